// File: sv/tmq_pkg.sv
// Shared widths, configuration layout and inter-stage structures of the tile map quad generator.
`default_nettype none

package tmq_pkg;

  localparam int unsigned COORD_W = 10;  // cell column and row
  localparam int unsigned SIZE_W  = 9;   // step, box and atlas-per-row sizes
  localparam int unsigned MAPC_W  = 11;  // map_columns
  localparam int unsigned TILE_W  = 16;  // tile number
  localparam int unsigned ORG_W   = 16;  // origin
  localparam int unsigned POS_W   = 20;
  localparam int unsigned SLOT_W  = 22;
  localparam int unsigned TEXU_W  = 17;
  localparam int unsigned TEXV_W  = 25;

  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS  = TILE_W / DIV_STAGES;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_PER_ROW = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLUMNS   = 3'd7;

  typedef struct packed {
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [SIZE_W-1:0] step_width;
    logic [SIZE_W-1:0] step_height;
    logic [SIZE_W-1:0] box_width;
    logic [SIZE_W-1:0] box_height;
    logic [SIZE_W-1:0] atlas_per_row;
    logic [MAPC_W-1:0] map_columns;
  } cfg_t;

  // Screen rectangle and slot base of one cell.
  typedef struct packed {
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [POS_W-1:0]  right;
    logic [POS_W-1:0]  bottom;
    logic [SLOT_W-1:0] base;
  } geom_t;

  // Everything needed to emit the four corners of one cell.
  typedef struct packed {
    geom_t             geo;
    logic [TEXU_W-1:0] u0;
    logic [TEXU_W-1:0] u1;
    logic [TEXV_W-1:0] v0;
    logic [TEXV_W-1:0] v1;
  } quad_t;

endpackage

`default_nettype wire

// File: sv/tmq_divider.sv
// Pipelined restoring divider that splits the tile number into atlas row and column.
`default_nettype none

module tmq_divider
  import tmq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [TILE_W-1:0] in_tile,
  input  wire logic [SIZE_W-1:0] in_div,
  output logic                   out_valid,
  output logic [TILE_W-1:0]      out_quot,
  output logic [SIZE_W-1:0]      out_rem
);

  logic [TILE_W-1:0] num_r [DIV_STAGES];
  logic [SIZE_W-1:0] rem_r [DIV_STAGES];
  logic [SIZE_W-1:0] div_r [DIV_STAGES];
  logic              vld_r [DIV_STAGES];

  logic [TILE_W-1:0] num_nxt [DIV_STAGES];
  logic [SIZE_W-1:0] rem_nxt [DIV_STAGES];
  logic [SIZE_W-1:0] div_nxt [DIV_STAGES];

  // Each stage retires DIV_STEPS quotient bits; the dividend shifts out of
  // the top of num while quotient bits shift in at the bottom.
  always_comb begin
    logic [TILE_W-1:0] num;
    logic [SIZE_W-1:0] rem;
    logic [SIZE_W-1:0] dv;
    logic [SIZE_W:0]   part;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        num = in_tile;
        rem = '0;
        dv  = in_div;
      end else begin
        num = num_r[s-1];
        rem = rem_r[s-1];
        dv  = div_r[s-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        part = {rem, num[TILE_W-1]};
        num  = {num[TILE_W-2:0], 1'b0};
        if (part >= {1'b0, dv}) begin
          part   = part - {1'b0, dv};
          num[0] = 1'b1;
        end
        rem = part[SIZE_W-1:0];
      end
      num_nxt[s] = num;
      rem_nxt[s] = rem;
      div_nxt[s] = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        num_r[s] <= num_nxt[s];
        rem_r[s] <= rem_nxt[s];
        div_r[s] <= div_nxt[s];
      end
    end
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_quot  = num_r[DIV_STAGES-1];
  assign out_rem   = rem_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: sv/tmq_geom.sv
// Screen rectangle and vertex slot base of a cell, in step with the divider stages.
`default_nettype none

module tmq_geom
  import tmq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire cfg_t               cfg,
  input  wire logic [COORD_W-1:0] cell_col,
  input  wire logic [COORD_W-1:0] cell_row,
  output geom_t                   geo
);

  logic [18:0]        px_r;
  logic [18:0]        py_r;
  logic [20:0]        ps_r;
  logic [COORD_W-1:0] col_r;

  logic [POS_W-1:0]   left_r;
  logic [POS_W-1:0]   top_r;
  logic [SLOT_W-1:0]  sum_r;

  geom_t              geo3_r;
  geom_t              geo4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // Products of cell position and spacing, and of row and map width.
      px_r  <= {9'd0, cell_col} * {10'd0, cfg.step_width};
      py_r  <= {9'd0, cell_row} * {10'd0, cfg.step_height};
      ps_r  <= {11'd0, cell_row} * {10'd0, cfg.map_columns};
      col_r <= cell_col;

      left_r <= {{(POS_W-ORG_W){cfg.origin_x[ORG_W-1]}}, cfg.origin_x} + {1'b0, px_r};
      top_r  <= {{(POS_W-ORG_W){cfg.origin_y[ORG_W-1]}}, cfg.origin_y} + {1'b0, py_r};
      sum_r  <= {1'b0, ps_r} + {12'd0, col_r};

      geo3_r.left   <= left_r;
      geo3_r.top    <= top_r;
      geo3_r.right  <= left_r + {11'd0, cfg.box_width};
      geo3_r.bottom <= top_r + {11'd0, cfg.box_height};
      geo3_r.base   <= {sum_r[SLOT_W-3:0], 2'b00};

      geo4_r <= geo3_r;
    end
  end

  assign geo = geo4_r;

endmodule

`default_nettype wire

// File: sv/tmq_tex.sv
// Texture coordinate stages: atlas column and row scaled by the box size.
`default_nettype none

module tmq_tex
  import tmq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  input  wire logic [TILE_W-1:0] in_quot,
  input  wire logic [SIZE_W-1:0] in_rem,
  input  wire geom_t             in_geo,
  output logic                   out_valid,
  output quad_t                  out_quad
);

  logic [17:0]       uprod_r;
  logic [TEXV_W-1:0] vprod_r;
  geom_t             geo_r;
  logic              vld_a_r;
  logic              vld_b_r;
  quad_t             quad_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uprod_r <= {9'd0, in_rem} * {9'd0, cfg.box_width};
      vprod_r <= {9'd0, in_quot} * {16'd0, cfg.box_height};
      geo_r   <= in_geo;

      // The far edge is one box further on; the sums wrap at field width.
      quad_r.geo <= geo_r;
      quad_r.u0  <= uprod_r[TEXU_W-1:0];
      quad_r.u1  <= uprod_r[TEXU_W-1:0] + {8'd0, cfg.box_width};
      quad_r.v0  <= vprod_r;
      quad_r.v1  <= vprod_r + {16'd0, cfg.box_height};
    end
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
    end
  end

  assign out_valid = vld_b_r;
  assign out_quad  = quad_r;

endmodule

`default_nettype wire

// File: sv/tmq_emit.sv
// Holds one finished cell and sends its four corner vertices, one per transaction.
`default_nettype none

module tmq_emit
  import tmq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire quad_t             in_quad,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             corner,
  output logic [SLOT_W-1:0]      vertex_slot,
  output logic [POS_W-1:0]       pos_x,
  output logic [POS_W-1:0]       pos_y,
  output logic [TEXU_W-1:0]      tex_u,
  output logic [TEXV_W-1:0]      tex_v,
  output logic                   last
);

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  quad_t      quad_r;
  logic       busy_r;
  logic [1:0] corner_r;
  logic       xfer;
  logic       rx;
  logic       by;

  assign xfer     = busy_r && out_ready;
  assign in_ready = !busy_r || (out_ready && corner_r == CORNER_BL);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      quad_r <= in_quad;
    end
    if (!rst_n) begin
      busy_r   <= 1'b0;
      corner_r <= CORNER_TL;
    end else if (in_valid && in_ready) begin
      busy_r   <= 1'b1;
      corner_r <= CORNER_TL;
    end else if (xfer) begin
      if (corner_r == CORNER_BL) begin
        busy_r <= 1'b0;
      end
      corner_r <= corner_r + 2'd1;
    end
  end

  assign rx = (corner_r == CORNER_TR) || (corner_r == CORNER_BR);
  assign by = (corner_r == CORNER_BR) || (corner_r == CORNER_BL);

  assign out_valid   = busy_r;
  assign corner      = corner_r;
  assign vertex_slot = {quad_r.geo.base[SLOT_W-1:2], corner_r};
  assign pos_x       = rx ? quad_r.geo.right : quad_r.geo.left;
  assign pos_y       = by ? quad_r.geo.bottom : quad_r.geo.top;
  assign tex_u       = rx ? quad_r.u1 : quad_r.u0;
  assign tex_v       = by ? quad_r.v1 : quad_r.v0;
  assign last        = (corner_r == CORNER_BL);

endmodule

`default_nettype wire

// File: sv/tile_map_quad_generator.sv
// A cell's first vertex is offered after the input register, divider stages, texture
// stages and emitter hold register. One vertex goes out per cycle while out_tready is
// high; the pipeline takes a cell each cycle unless held by the four-vertex output.
// The tile split runs through a 4-stage restoring divider, 4 quotient bits per stage.
// Reset (synchronous, rst_n low) empties the pipeline and restores register defaults.
`default_nettype none

module tile_map_quad_generator
  import tmq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: cell_col[9:0], cell_row[19:10], tile_number[35:20], zero [39:36]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: vertex_slot[21:0], pos_x[41:22], pos_y[61:42], tex_u[78:62], tex_v[103:79]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: corner[1:0]
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg_r;
  logic               en;

  logic               in_vld_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic [TILE_W-1:0]  tile_r;
  logic [SIZE_W-1:0]  per_row;

  logic               div_valid;
  logic [TILE_W-1:0]  div_quot;
  logic [SIZE_W-1:0]  div_rem;
  geom_t              geo;
  logic               tex_valid;
  quad_t              tex_quad;
  logic               emit_ready;

  logic [1:0]         corner;
  logic [SLOT_W-1:0]  vertex_slot;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [TEXU_W-1:0]  tex_u;
  logic [TEXV_W-1:0]  tex_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.step_width    <= 9'd32;
      cfg_r.step_height   <= 9'd32;
      cfg_r.box_width     <= 9'd32;
      cfg_r.box_height    <= 9'd32;
      cfg_r.atlas_per_row <= 9'd8;
      cfg_r.map_columns   <= 11'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:      cfg_r.origin_x      <= cfg_data;
        CFG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_data;
        CFG_STEP_WIDTH:    cfg_r.step_width    <= cfg_data[SIZE_W-1:0];
        CFG_STEP_HEIGHT:   cfg_r.step_height   <= cfg_data[SIZE_W-1:0];
        CFG_BOX_WIDTH:     cfg_r.box_width     <= cfg_data[SIZE_W-1:0];
        CFG_BOX_HEIGHT:    cfg_r.box_height    <= cfg_data[SIZE_W-1:0];
        CFG_ATLAS_PER_ROW: cfg_r.atlas_per_row <= cfg_data[SIZE_W-1:0];
        CFG_MAP_COLUMNS:   cfg_r.map_columns   <= cfg_data[MAPC_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it only holds when the output stage
  // cannot take the cell waiting at its end.
  assign en        = !tex_valid || emit_ready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      col_r  <= in_tdata[9:0];
      row_r  <= in_tdata[19:10];
      tile_r <= in_tdata[35:20];
    end
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
  end

  // An atlas width of zero behaves as one tile per row.
  assign per_row = (cfg_r.atlas_per_row == '0) ? 9'd1 : cfg_r.atlas_per_row;

  tmq_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_vld_r),
    .in_tile   (tile_r),
    .in_div    (per_row),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_rem   (div_rem)
  );

  tmq_geom u_geom (
    .clk      (clk),
    .en       (en),
    .cfg      (cfg_r),
    .cell_col (col_r),
    .cell_row (row_r),
    .geo      (geo)
  );

  tmq_tex u_tex (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (div_valid),
    .in_quot   (div_quot),
    .in_rem    (div_rem),
    .in_geo    (geo),
    .out_valid (tex_valid),
    .out_quad  (tex_quad)
  );

  tmq_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (tex_valid),
    .in_quad     (tex_quad),
    .in_ready    (emit_ready),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .corner      (corner),
    .vertex_slot (vertex_slot),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .last        (out_tlast)
  );

  assign out_tdata = {tex_v, tex_u, pos_y, pos_x, vertex_slot};
  assign out_tuser = corner;

endmodule

`default_nettype wire
